/* rtl/core/ehd_pkg.sv */
`timescale 1ns / 1ps

package ehd_pkg;

    localparam int QDepth = 4;
    localparam int PtrW   = $clog2(QDepth);
    localparam int CntW   = $clog2(QDepth + 1);

    localparam logic [11:0] WD_FIRST_YEAR_RST = 12'd2019;

    typedef enum logic [3:0] {
        KIND_NEW_YEAR      = 4'd0,
        KIND_WOMENS_DAY    = 4'd1,
        KIND_GOOD_FRIDAY   = 4'd2,
        KIND_EASTER_MONDAY = 4'd3,
        KIND_LABOUR_DAY    = 4'd4,
        KIND_ASCENSION     = 4'd5,
        KIND_WHIT_MONDAY   = 4'd6,
        KIND_UNITY_DAY     = 4'd7,
        KIND_CHRISTMAS1    = 4'd8,
        KIND_CHRISTMAS2    = 4'd9
    } t_kind;

    typedef enum logic {
        BK_IDLE,
        BK_EMIT
    } t_back_state;

    typedef struct packed {
        logic [5:0] easter;
        logic       wd;
    } t_item;

    typedef struct packed {
        logic [3:0] month;
        logic [4:0] day;
    } t_date;

    function automatic t_date date_from_offset(input logic [6:0] ofs);
        t_date      r;
        logic [6:0] v;
        v       = ofs;
        r.month = 4'd3;
        if (v >= 7'd31) begin
            v       = v - 7'd31;
            r.month = 4'd4;
            if (v >= 7'd30) begin
                v       = v - 7'd30;
                r.month = 4'd5;
                if (v >= 7'd31) begin
                    v       = v - 7'd31;
                    r.month = 4'd6;
                end
            end
        end
        r.day = 5'(v + 7'd1);
        return r;
    endfunction

endpackage

/* rtl/core/ehd_front.sv */
`timescale 1ns / 1ps

module ehd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [11:0]         i_year,
    input  logic                i_cfg_we,
    input  logic [11:0]         i_cfg_wdata,
    input  logic                i_pop,
    output logic                o_busy,
    output logic                o_push,
    output ehd_pkg::t_item      o_item
);
    import ehd_pkg::*;

    logic [11:0]     r_wd_first;
    logic [CntW-1:0] r_credit;
    logic [CntW-1:0] n_credit;
    logic            w_accept;

    // stage 1
    logic [23:0] w_p19;
    logic [24:0] w_p100;
    logic        r1_valid;
    logic [11:0] r1_year;
    logic [7:0]  r1_q19;
    logic [5:0]  r1_b;
    logic        r1_wd;

    // stage 2
    logic [11:0] w_a_full;
    logic [11:0] w_c_full;
    logic [5:0]  w_gx;
    logic [11:0] w_gp;
    logic        r2_valid;
    logic [4:0]  r2_a;
    logic [5:0]  r2_b;
    logic [3:0]  r2_d;
    logic [3:0]  r2_g;
    logic [1:0]  r2_e;
    logic [6:0]  r2_c;
    logic        r2_wd;

    // stage 3
    logic        r3_valid;
    logic [9:0]  r3_x;
    logic [4:0]  r3_a;
    logic [4:0]  r3_i;
    logic [1:0]  r3_kk;
    logic [1:0]  r3_e;
    logic        r3_wd;

    // stage 4
    logic [19:0] w_hp;
    logic        r4_valid;
    logic [3:0]  r4_hq;
    logic [9:0]  r4_x;
    logic [4:0]  r4_a;
    logic [4:0]  r4_i;
    logic [1:0]  r4_kk;
    logic [1:0]  r4_e;
    logic        r4_wd;

    // stage 5
    logic [9:0]  w_h_full;
    logic [4:0]  w_h;
    logic        r5_valid;
    logic [4:0]  r5_h;
    logic [6:0]  r5_y;
    logic [4:0]  r5_a;
    logic        r5_wd;

    // stage 6
    logic [16:0] w_lp;
    logic        r6_valid;
    logic [3:0]  r6_lq;
    logic [6:0]  r6_y;
    logic [4:0]  r6_h;
    logic [4:0]  r6_a;
    logic        r6_wd;

    // stage 7
    logic [6:0]  w_l_full;
    logic        r7_valid;
    logic [2:0]  r7_l;
    logic [4:0]  r7_h;
    logic [4:0]  r7_a;
    logic        r7_wd;

    // final
    logic [9:0]  w_msum;
    logic        w_m;

    assign o_busy   = (r_credit == CntW'(QDepth)) || !i_rst_n;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_credit = r_credit;
        if (w_accept && !i_pop) begin
            n_credit = r_credit + CntW'(1);
        end else if (!w_accept && i_pop) begin
            n_credit = r_credit - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wd_first <= WD_FIRST_YEAR_RST;
            r_credit   <= '0;
            r1_valid   <= 1'b0;
            r2_valid   <= 1'b0;
            r3_valid   <= 1'b0;
            r4_valid   <= 1'b0;
            r5_valid   <= 1'b0;
            r6_valid   <= 1'b0;
            r7_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_wd_first <= i_cfg_wdata;
            end
            r_credit <= n_credit;
            r1_valid <= w_accept;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
            r6_valid <= r5_valid;
            r7_valid <= r6_valid;
        end
    end

    // year / 19 and year / 100 by reciprocal
    assign w_p19  = 24'(i_year) * 24'd3450;
    assign w_p100 = 25'(i_year) * 25'd5243;

    always_ff @(posedge i_clk) begin
        r1_year <= i_year;
        r1_q19  <= w_p19[23:16];
        r1_b    <= w_p100[24:19];
        r1_wd   <= (i_year >= r_wd_first);
    end

    assign w_a_full = r1_year - 12'(r1_q19) * 12'd19;
    assign w_c_full = r1_year - 12'(r1_b) * 12'd100;
    assign w_gx     = r1_b - ((r1_b >= 6'd17) ? 6'd1 : 6'd0) + 6'd1;
    assign w_gp     = 12'(w_gx) * 12'd43;

    always_ff @(posedge i_clk) begin
        r2_a  <= w_a_full[4:0];
        r2_b  <= r1_b;
        r2_d  <= r1_b[5:2];
        r2_g  <= w_gp[10:7];
        r2_e  <= r1_b[1:0];
        r2_c  <= w_c_full[6:0];
        r2_wd <= r1_wd;
    end

    always_ff @(posedge i_clk) begin
        r3_x  <= 10'(r2_a) * 10'd19 + 10'(r2_b) + 10'd15 - 10'(r2_d) - 10'(r2_g);
        r3_a  <= r2_a;
        r3_i  <= r2_c[6:2];
        r3_kk <= r2_c[1:0];
        r3_e  <= r2_e;
        r3_wd <= r2_wd;
    end

    assign w_hp = 20'(r3_x) * 20'd2185;

    always_ff @(posedge i_clk) begin
        r4_hq <= w_hp[19:16];
        r4_x  <= r3_x;
        r4_a  <= r3_a;
        r4_i  <= r3_i;
        r4_kk <= r3_kk;
        r4_e  <= r3_e;
        r4_wd <= r3_wd;
    end

    assign w_h_full = r4_x - 10'(r4_hq) * 10'd30;
    assign w_h      = w_h_full[4:0];

    always_ff @(posedge i_clk) begin
        r5_h  <= w_h;
        r5_y  <= 7'd32 + 7'(r4_e) * 7'd2 + 7'(r4_i) * 7'd2 - 7'(w_h) - 7'(r4_kk);
        r5_a  <= r4_a;
        r5_wd <= r4_wd;
    end

    assign w_lp = 17'(r5_y) * 17'd147;

    always_ff @(posedge i_clk) begin
        r6_lq <= w_lp[13:10];
        r6_y  <= r5_y;
        r6_h  <= r5_h;
        r6_a  <= r5_a;
        r6_wd <= r5_wd;
    end

    assign w_l_full = r6_y - 7'(r6_lq) * 7'd7;

    always_ff @(posedge i_clk) begin
        r7_l  <= w_l_full[2:0];
        r7_h  <= r6_h;
        r7_a  <= r6_a;
        r7_wd <= r6_wd;
    end

    assign w_msum = 10'(r7_a) + 10'(r7_h) * 10'd11 + 10'(r7_l) * 10'd22;
    assign w_m    = (w_msum >= 10'd451);

    assign o_push        = r7_valid;
    assign o_item.easter = 6'(7'(r7_h) + 7'(r7_l) + 7'd21 - (w_m ? 7'd7 : 7'd0));
    assign o_item.wd     = r7_wd;

endmodule

/* rtl/core/ehd_queue.sv */
`timescale 1ns / 1ps

module ehd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ehd_pkg::t_item  i_item,
    input  logic            i_pop,
    output logic            o_valid,
    output ehd_pkg::t_item  o_item
);
    import ehd_pkg::*;

    t_item           r_mem [QDepth];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PtrW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PtrW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CntW'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CntW'(1);
            end
        end
    end

endmodule

/* rtl/core/ehd_back.sv */
`timescale 1ns / 1ps

module ehd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  ehd_pkg::t_item  i_q_item,
    output logic            o_pop,
    output logic            o_strobe,
    output logic [3:0]      o_month,
    output logic [4:0]      o_day,
    output logic [3:0]      o_kind,
    output logic            o_last
);
    import ehd_pkg::*;

    t_back_state r_state;
    t_back_state n_state;
    t_kind       r_kind;
    t_kind       n_kind;
    logic [5:0]  r_easter;
    logic [5:0]  n_easter;
    logic        r_wd;
    logic        n_wd;
    logic        w_emit;
    logic        w_done;
    logic [6:0]  w_ofs;
    t_date       w_date;

    logic        r_strobe;
    logic [3:0]  r_month;
    logic [4:0]  r_day;
    logic [3:0]  r_out_kind;
    logic        r_last;

    assign w_done = (r_kind == KIND_CHRISTMAS2);

    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_done && !i_q_valid) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        w_emit   = (r_state == BK_EMIT);
        o_pop    = i_q_valid && (!w_emit || w_done);
        n_kind   = r_kind;
        n_easter = r_easter;
        n_wd     = r_wd;
        if (o_pop) begin
            n_kind   = KIND_NEW_YEAR;
            n_easter = i_q_item.easter;
            n_wd     = i_q_item.wd;
        end else if (w_emit) begin
            case (r_kind)
                KIND_NEW_YEAR:      n_kind = r_wd ? KIND_WOMENS_DAY : KIND_GOOD_FRIDAY;
                KIND_WOMENS_DAY:    n_kind = KIND_GOOD_FRIDAY;
                KIND_GOOD_FRIDAY:   n_kind = KIND_EASTER_MONDAY;
                KIND_EASTER_MONDAY: n_kind = KIND_LABOUR_DAY;
                KIND_LABOUR_DAY:    n_kind = KIND_ASCENSION;
                KIND_ASCENSION:     n_kind = KIND_WHIT_MONDAY;
                KIND_WHIT_MONDAY:   n_kind = KIND_UNITY_DAY;
                KIND_UNITY_DAY:     n_kind = KIND_CHRISTMAS1;
                KIND_CHRISTMAS1:    n_kind = KIND_CHRISTMAS2;
                default:            n_kind = KIND_CHRISTMAS2;
            endcase
        end
    end

    always_comb begin
        case (r_kind)
            KIND_GOOD_FRIDAY:   w_ofs = 7'(r_easter) - 7'd2;
            KIND_EASTER_MONDAY: w_ofs = 7'(r_easter) + 7'd1;
            KIND_ASCENSION:     w_ofs = 7'(r_easter) + 7'd39;
            KIND_WHIT_MONDAY:   w_ofs = 7'(r_easter) + 7'd50;
            default:            w_ofs = 7'(r_easter);
        endcase
        w_date = date_from_offset(w_ofs);
        case (r_kind)
            KIND_NEW_YEAR:   w_date = '{month: 4'd1,  day: 5'd1};
            KIND_WOMENS_DAY: w_date = '{month: 4'd3,  day: 5'd8};
            KIND_LABOUR_DAY: w_date = '{month: 4'd5,  day: 5'd1};
            KIND_UNITY_DAY:  w_date = '{month: 4'd10, day: 5'd3};
            KIND_CHRISTMAS1: w_date = '{month: 4'd12, day: 5'd25};
            KIND_CHRISTMAS2: w_date = '{month: 4'd12, day: 5'd26};
            default:         w_date = w_date;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_kind   <= KIND_NEW_YEAR;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_kind   <= n_kind;
            r_strobe <= w_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_easter   <= n_easter;
        r_wd       <= n_wd;
        r_month    <= w_date.month;
        r_day      <= w_date.day;
        r_out_kind <= 4'(r_kind);
        r_last     <= w_done;
    end

    assign o_strobe = r_strobe;
    assign o_month  = r_month;
    assign o_day    = r_day;
    assign o_kind   = r_out_kind;
    assign o_last   = r_last;

endmodule

/* rtl/core/easter_holiday_date_generator_top.sv */
`timescale 1ns / 1ps

// Public holiday generator. A year is taken on a clock edge with start high and busy
// low; the block finds Easter Sunday in a seven-stage arithmetic pipeline and then
// emits the year's holidays on o_strobe as one unbroken burst of ten results (nine
// when the year lies before the configured first year), one per cycle, the last
// marked by o_last. With the output side idle, a year's first result passes through
// the pipeline and the queue to the registered output stage. Years may be requested
// on consecutive cycles; busy rises once four requests are held in the pipeline and
// the queue ahead of the output stage, so the sustained rate of years is set by the
// one-result-per-cycle output.
// The receiver cannot stall: every strobe must be captured. Write i_cfg_wdata only
// while no request is outstanding.
module easter_holiday_date_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] i_year,
    input  logic        i_cfg_we,
    input  logic [11:0] i_cfg_wdata,
    output logic        o_strobe,
    output logic [3:0]  o_month,
    output logic [4:0]  o_day,
    output logic [3:0]  o_holiday_kind,
    output logic        o_last
);
    import ehd_pkg::*;

    logic  w_push;
    t_item w_push_item;
    logic  w_q_valid;
    t_item w_q_item;
    logic  w_pop;

    ehd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_year      (i_year),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop       (w_pop),
        .o_busy      (busy),
        .o_push      (w_push),
        .o_item      (w_push_item)
    );

    ehd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    ehd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_item  (w_q_item),
        .o_pop     (w_pop),
        .o_strobe  (o_strobe),
        .o_month   (o_month),
        .o_day     (o_day),
        .o_kind    (o_holiday_kind),
        .o_last    (o_last)
    );

`ifndef SYNTH
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("holiday burst broken before its last result");

    a_last_is_christmas2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_last == (o_holiday_kind == KIND_CHRISTMAS2)))
        else $error("last flag not aligned with second Christmas day");

    a_good_friday_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_holiday_kind == KIND_GOOD_FRIDAY)) |->
            (o_month == 4'd3 || o_month == 4'd4))
        else $error("Good Friday outside March and April");

    a_burst_opens_new_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_last)) |-> (o_holiday_kind == KIND_NEW_YEAR))
        else $error("burst does not open with New Year");
`endif

endmodule

/* tb/sv/easter_holiday_date_generator_top_tb.sv */
`timescale 1ns / 1ps

module easter_holiday_date_generator_top_tb;

    import ehd_pkg::*;

    typedef struct {
        logic [3:0] month;
        logic [4:0] day;
        t_kind      kind;
        logic       last;
    } t_holiday;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [11:0] i_year;
    logic        i_cfg_we;
    logic [11:0] i_cfg_wdata;
    logic        o_strobe;
    logic [3:0]  o_month;
    logic [4:0]  o_day;
    logic [3:0]  o_holiday_kind;
    logic        o_last;

    t_holiday    holiday_q[$];
    t_holiday    due_holiday;
    logic [11:0] wd_first_year;
    int unsigned mismatch_count;
    bit          no_gaps;

    easter_holiday_date_generator_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_year         (i_year),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_month        (o_month),
        .o_day          (o_day),
        .o_holiday_kind (o_holiday_kind),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void push_holiday(input logic [3:0] mon, input logic [4:0] dd,
                                         input t_kind kind, input logic lst);
        t_holiday h;
        h.month = mon;
        h.day   = dd;
        h.kind  = kind;
        h.last  = lst;
        holiday_q.push_back(h);
    endfunction

    // ofs counts days after March 1
    function automatic void push_rolling(input int unsigned ofs, input t_kind kind);
        int unsigned v;
        logic [3:0]  mon;
        v   = ofs;
        mon = 4'd3;
        if (v >= 31) begin
            v   = v - 31;
            mon = 4'd4;
            if (v >= 30) begin
                v   = v - 30;
                mon = 4'd5;
                if (v >= 31) begin
                    v   = v - 31;
                    mon = 4'd6;
                end
            end
        end
        push_holiday(mon, 5'(v + 1), kind, 1'b0);
    endfunction

    function automatic void predict_holidays(input logic [11:0] yr);
        int unsigned y, a, b, c, d, e, f, g, h, q4, r4, l, m, s, easter_ofs;
        y = yr;
        a = y % 19;
        b = y / 100;
        c = y % 100;
        d = b / 4;
        e = b % 4;
        f = (b + 8) / 25;
        g = (b - f + 1) / 3;
        h = (19 * a + b - d - g + 15) % 30;
        q4 = c / 4;
        r4 = c % 4;
        l = (32 + 2 * e + 2 * q4 - h - r4) % 7;
        m = (a + 11 * h + 22 * l) / 451;
        s = h + l + 114 - 7 * m;
        easter_ofs = (s / 31 == 3) ? (s % 31) : (31 + s % 31);
        push_holiday(4'd1, 5'd1, KIND_NEW_YEAR, 1'b0);
        if (yr >= wd_first_year)
            push_holiday(4'd3, 5'd8, KIND_WOMENS_DAY, 1'b0);
        push_rolling(easter_ofs - 2, KIND_GOOD_FRIDAY);
        push_rolling(easter_ofs + 1, KIND_EASTER_MONDAY);
        push_holiday(4'd5, 5'd1, KIND_LABOUR_DAY, 1'b0);
        push_rolling(easter_ofs + 39, KIND_ASCENSION);
        push_rolling(easter_ofs + 50, KIND_WHIT_MONDAY);
        push_holiday(4'd10, 5'd3, KIND_UNITY_DAY, 1'b0);
        push_holiday(4'd12, 5'd25, KIND_CHRISTMAS1, 1'b0);
        push_holiday(4'd12, 5'd26, KIND_CHRISTMAS2, 1'b1);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) begin
            if (holiday_q.size() == 0) begin
                $error("unexpected holiday: month %0d day %0d kind %0d last %0d",
                       o_month, o_day, o_holiday_kind, o_last);
                mismatch_count++;
            end else begin
                due_holiday = holiday_q.pop_front();
                if (o_month !== due_holiday.month) begin
                    $error("month: expected %0d, got %0d", due_holiday.month, o_month);
                    mismatch_count++;
                end
                if (o_day !== due_holiday.day) begin
                    $error("day: expected %0d, got %0d", due_holiday.day, o_day);
                    mismatch_count++;
                end
                if (o_holiday_kind !== due_holiday.kind) begin
                    $error("holiday_kind: expected %0d, got %0d",
                           due_holiday.kind, o_holiday_kind);
                    mismatch_count++;
                end
                if (o_last !== due_holiday.last) begin
                    $error("last: expected %0d, got %0d", due_holiday.last, o_last);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic send_year(input logic [11:0] yr);
        int unsigned gap;
        start  <= 1'b1;
        i_year <= yr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_holidays(yr);
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // drop the request and let every pending holiday drain
    task automatic wait_idle();
        start <= 1'b0;
        while (holiday_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
    endtask

    task automatic write_wd_first_year(input logic [11:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        wd_first_year = value;
    endtask

    task automatic test_reset_value();
        send_year(12'd2018);
        send_year(12'd2019);
        send_year(12'd2020);
    endtask

    task automatic test_directed_years();
        logic [11:0] years[$];
        years = '{12'd0, 12'd1, 12'd1582, 12'd1583, 12'd1818, 12'd2285, 12'd1954,
                  12'd1981, 12'd2008, 12'd2011, 12'd2038, 12'd2049, 12'd2076,
                  12'd2048, 12'd3000, 12'd4095};
        foreach (years[n]) send_year(years[n]);
    endtask

    task automatic test_config_extremes();
        write_wd_first_year(12'd0);
        send_year(12'd0);
        send_year(12'd4095);
        write_wd_first_year(12'd4095);
        send_year(12'd4094);
        send_year(12'd4095);
        write_wd_first_year(12'd1583);
        send_year(12'd1582);
        send_year(12'd1583);
    endtask

    task automatic test_random_years();
        logic [11:0] settings[$];
        logic [11:0] yr;
        int          near;
        settings = '{12'($urandom_range(0, 4095)), 12'd0, 12'd4095, 12'd1583,
                     12'd2019, 12'($urandom_range(1583, 4095))};
        foreach (settings[p]) begin
            write_wd_first_year(settings[p]);
            for (int n = 0; n < 40; n++) begin
                if (n % 10 == 0)
                    no_gaps = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 3) == 0) begin
                    // hold near the configured first year
                    near = int'(wd_first_year) + $urandom_range(0, 4) - 2;
                    yr   = (near < 0) ? 12'd0 : (near > 4095) ? 12'd4095 : 12'(near);
                end else begin
                    yr = 12'($urandom_range(0, 4095));
                end
                send_year(yr);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_year      <= 12'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 12'd0;
        wd_first_year  = WD_FIRST_YEAR_RST;
        mismatch_count = 0;
        no_gaps        = 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_value();
        test_directed_years();
        test_config_extremes();
        test_random_years();

        wait_idle();
        repeat (30) @(posedge i_clk);
        if (holiday_q.size() != 0) begin
            $error("%0d holidays never arrived", holiday_q.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/core/ehd_pkg.sv
rtl/core/ehd_front.sv
rtl/core/ehd_queue.sv
rtl/core/ehd_back.sv
rtl/core/easter_holiday_date_generator_top.sv
tb/sv/easter_holiday_date_generator_top_tb.sv
